@@ rtl/oprt_pkg.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Ordered position reorder table package
// Shared field widths, operation and status codes, controller states and the
// command and status groups between the controller and the datapath.
// -----------------------------------------------------------------------------
package oprt_pkg;

   // Field widths that the word format fixes.
   localparam int MODE_W   = 2;
   localparam int SLOT_W   = 4;
   localparam int PLACE_W  = 4;
   localparam int STATUS_W = 2;

   // Number of slots that the slot field can address.
   localparam int SLOT_COUNT = 1 << SLOT_W;

   // Operation codes carried in the mode field.
   typedef enum logic [MODE_W-1:0] {
      MODE_WRITE  = 2'd0,
      MODE_BEFORE = 2'd1,
      MODE_AFTER  = 2'd2,
      MODE_QUERY  = 2'd3
   } mode_type;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NO_ID     = 2'd1,
      STATUS_NO_ANCHOR = 2'd2
   } status_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_APPLY
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;
      logic match;
      logic apply;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
   } stat_type;

endpackage

@@ rtl/oprt_req_if.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Request channel interface
// Valid/ready channel carrying one request word of the reorder table.
// -----------------------------------------------------------------------------
interface oprt_req_if #(
   parameter int ID_BITS = 16
);
   logic                         valid;
   logic                         ready;
   logic [oprt_pkg::MODE_W-1:0]  mode;
   logic [oprt_pkg::SLOT_W-1:0]  slot;
   logic [ID_BITS-1:0]           item_id;
   logic [ID_BITS-1:0]           anchor_id;
   logic [oprt_pkg::PLACE_W-1:0] place;

   modport source (output valid, output mode, output slot, output item_id,
                   output anchor_id, output place, input ready);
   modport sink (input valid, input mode, input slot, input item_id,
                 input anchor_id, input place, output ready);
endinterface

@@ rtl/oprt_rsp_if.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Response channel interface
// Valid/ready channel carrying one result word of the reorder table.
// -----------------------------------------------------------------------------
interface oprt_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [oprt_pkg::STATUS_W-1:0] status;
   logic [oprt_pkg::PLACE_W-1:0]  new_place;

   modport source (output valid, output status, output new_place, input ready);
   modport sink (input valid, input status, input new_place, output ready);
endinterface

@@ rtl/oprt_ctrl.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Reorder table controller
// Sequences each request word through a match cycle and an apply cycle and
// accepts the next word in the apply cycle once the result register is free.
// -----------------------------------------------------------------------------
module oprt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  oprt_pkg::stat_type stat,
   output oprt_pkg::cmd_type  cmd
);

   oprt_pkg::state_type state_ff;
   oprt_pkg::state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= oprt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      cmd.load_req = 1'b0;
      cmd.match    = 1'b0;
      cmd.apply    = 1'b0;
      unique case (state_ff)
         oprt_pkg::ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
            if (req_valid) begin
               state_in = oprt_pkg::ST_MATCH;
            end
         end
         oprt_pkg::ST_MATCH: begin
            cmd.match = 1'b1;
            state_in  = oprt_pkg::ST_APPLY;
         end
         oprt_pkg::ST_APPLY: begin
            // The table update and the result load happen together, so both
            // wait for room in the result register.
            if (stat.out_free) begin
               cmd.apply    = 1'b1;
               req_ready    = 1'b1;
               cmd.load_req = req_valid;
               state_in     = req_valid ? oprt_pkg::ST_MATCH : oprt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = oprt_pkg::ST_IDLE;
         end
      endcase
   end

   // A result is never loaded over one that has not been taken.
   assert property (@(posedge clock) disable iff (reset)
      cmd.apply |-> stat.out_free)
      else $error("apply issued while the result register is occupied");

   // Every match cycle is followed by an apply cycle.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == oprt_pkg::ST_MATCH |=> state_ff == oprt_pkg::ST_APPLY)
      else $error("match cycle not followed by apply");

   // An accepted word always starts a match cycle.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_req |=> state_ff == oprt_pkg::ST_MATCH)
      else $error("accepted word did not start a match");

endmodule

@@ rtl/oprt_dp.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Reorder table datapath
// Holds the entry table, matches the id and anchor against every entry,
// renumbers all entries in parallel and keeps the result register.
// -----------------------------------------------------------------------------
module oprt_dp #(
   parameter int DEPTH   = 16,
   parameter int ID_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  oprt_pkg::cmd_type             cmd,
   output oprt_pkg::stat_type            stat,
   input  logic [oprt_pkg::MODE_W-1:0]   req_mode,
   input  logic [oprt_pkg::SLOT_W-1:0]   req_slot,
   input  logic [ID_BITS-1:0]            req_item_id,
   input  logic [ID_BITS-1:0]            req_anchor_id,
   input  logic [oprt_pkg::PLACE_W-1:0]  req_place,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [oprt_pkg::STATUS_W-1:0] rsp_status,
   output logic [oprt_pkg::PLACE_W-1:0]  rsp_new_place
);

   // Only slots that the slot field can reach are ever written, so no more
   // rows than that are kept.
   localparam int ROWS  = (DEPTH < oprt_pkg::SLOT_COUNT) ? DEPTH : oprt_pkg::SLOT_COUNT;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int PLACES = 1 << oprt_pkg::PLACE_W;
   localparam logic [ID_BITS-1:0] ANCHOR_HEAD = '0;
   localparam logic [ID_BITS-1:0] ANCHOR_TAIL = '1;
   localparam logic [oprt_pkg::PLACE_W-1:0] PLACE_ONE = oprt_pkg::PLACE_W'(1);

   // Captured request word.
   oprt_pkg::mode_type           mode_ff;
   logic [oprt_pkg::SLOT_W-1:0]  slot_ff;
   logic [ID_BITS-1:0]           id_ff;
   logic [ID_BITS-1:0]           anchor_ff;
   logic [oprt_pkg::PLACE_W-1:0] place_ff;

   // Entry table.
   logic [ROWS-1:0]              valid_ff;
   logic [ROWS-1:0]              valid_in;
   logic [ID_BITS-1:0]           key_ff [ROWS];
   logic [ID_BITS-1:0]           key_in [ROWS];
   logic [oprt_pkg::PLACE_W-1:0] pos_ff [ROWS];
   logic [oprt_pkg::PLACE_W-1:0] pos_in [ROWS];

   // Match results.
   logic [ROWS-1:0]              mv_oh_ff;
   logic [ROWS-1:0]              mv_oh_in;
   logic [ROWS-1:0]              an_oh_ff;
   logic [ROWS-1:0]              an_oh_in;
   logic [oprt_pkg::PLACE_W-1:0] cur_ff;
   logic [oprt_pkg::PLACE_W-1:0] cur_in;
   logic [oprt_pkg::PLACE_W-1:0] anc_ff;
   logic [oprt_pkg::PLACE_W-1:0] anc_in;
   logic [oprt_pkg::PLACE_W-1:0] top_ff;
   logic [oprt_pkg::PLACE_W-1:0] top_in;

   // Result register.
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   oprt_pkg::status_type         rsp_status_ff;
   oprt_pkg::status_type         rsp_status_in;
   logic [oprt_pkg::PLACE_W-1:0] rsp_place_ff;
   logic [oprt_pkg::PLACE_W-1:0] rsp_place_in;

   // Apply-cycle decode.
   logic                         mv_found;
   logic                         an_found;
   logic                         is_head;
   logic                         is_tail;
   logic                         is_after;
   logic                         slot_ok;
   logic                         move_en;
   logic                         write_en;
   logic [oprt_pkg::PLACE_W-1:0] mv_new;

   // Capture the request word on acceptance.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         mode_ff   <= oprt_pkg::mode_type'(req_mode);
         slot_ff   <= req_slot;
         id_ff     <= req_item_id;
         anchor_ff <= req_anchor_id;
         place_ff  <= req_place;
      end
   end

   // Match cycle: lowest matching slot for id and anchor, their positions
   // and the largest position held by any valid entry.
   always_comb begin
      logic [ROWS-1:0]   mv_hit;
      logic [ROWS-1:0]   an_hit;
      logic [PLACES-1:0] seen;
      for (int i = 0; i < ROWS; i++) begin
         mv_hit[i] = valid_ff[i] && (key_ff[i] == id_ff);
         an_hit[i] = valid_ff[i] && (key_ff[i] == anchor_ff);
      end
      mv_oh_in = mv_hit & (~mv_hit + ROWS'(1));
      an_oh_in = an_hit & (~an_hit + ROWS'(1));
      cur_in   = '0;
      anc_in   = '0;
      seen     = '0;
      for (int i = 0; i < ROWS; i++) begin
         if (mv_oh_in[i]) begin
            cur_in = cur_in | pos_ff[i];
         end
         if (an_oh_in[i]) begin
            anc_in = anc_in | pos_ff[i];
         end
         if (valid_ff[i]) begin
            seen[pos_ff[i]] = 1'b1;
         end
      end
      top_in = '0;
      for (int p = 0; p < PLACES; p++) begin
         if (seen[p]) begin
            top_in = oprt_pkg::PLACE_W'(p);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mv_oh_ff <= '0;
         an_oh_ff <= '0;
      end else if (cmd.match) begin
         mv_oh_ff <= mv_oh_in;
         an_oh_ff <= an_oh_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.match) begin
         cur_ff <= cur_in;
         anc_ff <= anc_in;
         top_ff <= top_in;
      end
   end

   // Apply cycle: classify the operation and work out the moved position.
   always_comb begin
      mv_found = |mv_oh_ff;
      an_found = |an_oh_ff;
      is_head  = (anchor_ff == ANCHOR_HEAD);
      is_tail  = (anchor_ff == ANCHOR_TAIL);
      is_after = (mode_ff == oprt_pkg::MODE_AFTER);
      slot_ok  = ({1'b0, slot_ff} < (oprt_pkg::SLOT_W + 1)'(ROWS));
      write_en = cmd.apply && (mode_ff == oprt_pkg::MODE_WRITE);
      move_en  = cmd.apply && mv_found && (mode_ff == oprt_pkg::MODE_BEFORE ||
                 mode_ff == oprt_pkg::MODE_AFTER) && (is_head || is_tail || an_found);
      if (is_head) begin
         mv_new = '0;
      end else if (is_tail) begin
         mv_new = top_ff;
      end else if (cur_ff < anc_ff) begin
         mv_new = is_after ? anc_ff : anc_ff - PLACE_ONE;
      end else if (cur_ff > anc_ff) begin
         mv_new = is_after ? anc_ff + PLACE_ONE : anc_ff;
      end else begin
         mv_new = cur_ff;
      end
   end

   // Table next state: one slot load, or every valid entry renumbered at once.
   always_comb begin
      logic [oprt_pkg::PLACE_W-1:0] p;
      logic [oprt_pkg::PLACE_W-1:0] np;
      valid_in = valid_ff;
      for (int i = 0; i < ROWS; i++) begin
         key_in[i] = key_ff[i];
         p         = pos_ff[i];
         np        = p;
         if (move_en && valid_ff[i]) begin
            if (mv_oh_ff[i]) begin
               np = mv_new;
            end else if (is_head) begin
               if (p < cur_ff) begin
                  np = p + PLACE_ONE;
               end
            end else if (is_tail) begin
               if (p > cur_ff) begin
                  np = p - PLACE_ONE;
               end
            end else if (p < cur_ff && p < anc_ff) begin
               np = p;
            end else if (p > cur_ff && p < anc_ff) begin
               np = p - PLACE_ONE;
            end else if (p > anc_ff && p < cur_ff) begin
               np = p + PLACE_ONE;
            end else if (an_oh_ff[i]) begin
               // The anchor steps aside when the moved entry crosses it.
               if (!is_after && anc_ff < cur_ff) begin
                  np = anc_ff + PLACE_ONE;
               end else if (is_after && anc_ff > cur_ff) begin
                  np = anc_ff - PLACE_ONE;
               end
            end
         end
         if (write_en && slot_ok && slot_ff[ROW_W-1:0] == ROW_W'(i)) begin
            valid_in[i] = 1'b1;
            key_in[i]   = id_ff;
            np          = place_ff;
         end
         pos_in[i] = np;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ROWS; i++) begin
         key_ff[i] <= key_in[i];
         pos_ff[i] <= pos_in[i];
      end
   end

   // Result word.
   always_comb begin
      rsp_status_in = oprt_pkg::STATUS_OK;
      rsp_place_in  = '0;
      if (mode_ff == oprt_pkg::MODE_WRITE) begin
         rsp_place_in = slot_ok ? place_ff : '0;
      end else if (!mv_found) begin
         rsp_status_in = oprt_pkg::STATUS_NO_ID;
      end else if (mode_ff == oprt_pkg::MODE_QUERY) begin
         rsp_place_in = cur_ff;
      end else if (!is_head && !is_tail && !an_found) begin
         rsp_status_in = oprt_pkg::STATUS_NO_ANCHOR;
      end else begin
         rsp_place_in = mv_new;
      end
   end

   // Result register: loaded in the apply cycle, emptied when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.apply) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.apply) begin
         rsp_status_ff <= rsp_status_in;
         rsp_place_ff  <= rsp_place_in;
      end
   end

   assign stat.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = oprt_pkg::STATUS_W'(rsp_status_ff);
   assign rsp_new_place = rsp_place_ff;

   // At most one slot is taken as the moved entry.
   assert property (@(posedge clock) disable iff (reset) $onehot0(mv_oh_ff))
      else $error("moved id matched more than one slot");

   // At most one slot is taken as the anchor.
   assert property (@(posedge clock) disable iff (reset) $onehot0(an_oh_ff))
      else $error("anchor id matched more than one slot");

   // An error result carries position zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != oprt_pkg::STATUS_OK |-> rsp_place_ff == '0)
      else $error("error result with a nonzero position");

endmodule

@@ rtl/ordered_position_reorder_table_unit.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Ordered position reorder table unit
// Table of id/position entries with slot writes, moves before or after an
// anchor (or to head and tail) and position queries.
//
//   Channel   Role     Word
//   req_chan  sink     mode, slot, item_id, anchor_id, place
//   rsp_chan  source   status, new_place
//
// Each word passes through a match cycle that compares id and anchor with
// every entry and finds the largest position, and an apply cycle that
// renumbers all entries in parallel and loads the result register. The next
// word is accepted in the apply cycle, while the current word is finished.
// Reset clears the entry valid bits.
// The apply cycle waits while an earlier result has not been taken.
// -----------------------------------------------------------------------------
module ordered_position_reorder_table_unit #(
   parameter int DEPTH   = 16,
   parameter int ID_BITS = 16
) (
   input logic        clock,
   input logic        reset,
   oprt_req_if.sink   req_chan,
   oprt_rsp_if.source rsp_chan
);

   oprt_pkg::cmd_type  cmd;
   oprt_pkg::stat_type stat;
   logic               req_ready;

   // Sequencing.
   oprt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Table and result register.
   oprt_dp #(
      .DEPTH   (DEPTH),
      .ID_BITS (ID_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_mode      (req_chan.mode),
      .req_slot      (req_chan.slot),
      .req_item_id   (req_chan.item_id),
      .req_anchor_id (req_chan.anchor_id),
      .req_place     (req_chan.place),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_status    (rsp_chan.status),
      .rsp_new_place (rsp_chan.new_place)
   );

   assign req_chan.ready = req_ready;

endmodule

@@ bench/ordered_position_reorder_table_unit_tb.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Ordered position reorder table unit testbench
// Drives request words into the table and checks every result word against a
// predicted copy of the table. A short directed run covers the head and tail
// codes, duplicate ids, a missing id or anchor and an anchor equal to the
// moved id. Random phases follow, each of which loads the table with a
// shuffled order first. Sender bursts, receiver stalls, a long receiver
// hold-off and a full drain between phases put gaps on every cycle of the
// block's work.
// -----------------------------------------------------------------------------
module ordered_position_reorder_table_unit_tb;

   localparam int TABLE_DEPTH = 16;
   localparam int ID_W        = 16;
   localparam logic [ID_W-1:0] HEAD_CODE = '0;
   localparam logic [ID_W-1:0] TAIL_CODE = '1;
   localparam int IDLE_LIMIT   = 1000;
   localparam int LONG_HOLD    = 80;
   localparam int PHASE_WORDS  = 80;
   localparam int PHASE_COUNT  = 5;

   // Expected result word.
   typedef struct {
      oprt_pkg::status_type              status;
      logic [oprt_pkg::PLACE_W-1:0]      place;
   } reply_word_type;

   // Predicted table and queue of the result words still to come.
   class place_table_scoreboard;
      bit                           entry_valid [TABLE_DEPTH];
      logic [ID_W-1:0]              entry_key   [TABLE_DEPTH];
      logic [oprt_pkg::PLACE_W-1:0] entry_place [TABLE_DEPTH];
      reply_word_type               expected_replies [$];
      int errors;
      int n_write, n_move, n_head, n_tail, n_query, n_no_id, n_no_anchor;

      // Lowest valid slot that holds the key, or -1.
      function int lowest_match(logic [ID_W-1:0] key);
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (entry_valid[i] && entry_key[i] == key) return i;
         end
         return -1;
      endfunction

      // Apply one accepted request word to the table and queue its result.
      function void note_request(oprt_pkg::mode_type mode,
                                 logic [oprt_pkg::SLOT_W-1:0] slot,
                                 logic [ID_W-1:0] id, logic [ID_W-1:0] anchor,
                                 logic [oprt_pkg::PLACE_W-1:0] place);
         reply_word_type               r;
         int                           mv;
         int                           an;
         logic [oprt_pkg::PLACE_W-1:0] cur;
         logic [oprt_pkg::PLACE_W-1:0] anc;
         logic [oprt_pkg::PLACE_W-1:0] top;
         logic [oprt_pkg::PLACE_W-1:0] p;
         bit                           after;
         r.status = oprt_pkg::STATUS_OK;
         r.place  = '0;
         if (mode == oprt_pkg::MODE_WRITE) begin
            n_write++;
            if (slot < TABLE_DEPTH) begin
               entry_valid[slot] = 1'b1;
               entry_key[slot]   = id;
               entry_place[slot] = place;
               r.place = place;
            end
         end else begin
            mv = lowest_match(id);
            if (mode == oprt_pkg::MODE_QUERY) n_query++;
            else n_move++;
            if (mv < 0) begin
               r.status = oprt_pkg::STATUS_NO_ID;
               n_no_id++;
            end else if (mode == oprt_pkg::MODE_QUERY) begin
               r.place = entry_place[mv];
            end else if (anchor == HEAD_CODE) begin
               // Moved entry to the front; everything ahead of it slips back.
               n_head++;
               cur = entry_place[mv];
               for (int i = 0; i < TABLE_DEPTH; i++) begin
                  if (!entry_valid[i]) continue;
                  if (i == mv) entry_place[i] = '0;
                  else if (entry_place[i] < cur) entry_place[i] = entry_place[i] + 1'b1;
               end
               r.place = entry_place[mv];
            end else if (anchor == TAIL_CODE) begin
               // Moved entry takes the largest position held before the move.
               n_tail++;
               cur = entry_place[mv];
               top = '0;
               for (int i = 0; i < TABLE_DEPTH; i++) begin
                  if (entry_valid[i] && entry_place[i] > top) top = entry_place[i];
               end
               for (int i = 0; i < TABLE_DEPTH; i++) begin
                  if (!entry_valid[i] || i == mv) continue;
                  if (entry_place[i] > cur) entry_place[i] = entry_place[i] - 1'b1;
               end
               entry_place[mv] = top;
               r.place = top;
            end else begin
               an = lowest_match(anchor);
               if (an < 0) begin
                  r.status = oprt_pkg::STATUS_NO_ANCHOR;
                  n_no_anchor++;
               end else begin
                  // Renumber every entry from the positions held before the move.
                  after = (mode == oprt_pkg::MODE_AFTER);
                  cur   = entry_place[mv];
                  anc   = entry_place[an];
                  for (int i = 0; i < TABLE_DEPTH; i++) begin
                     if (!entry_valid[i]) continue;
                     p = entry_place[i];
                     if (i == mv) begin
                        if (p < anc) p = after ? anc : anc - 1'b1;
                        else if (p > anc) p = after ? anc + 1'b1 : anc;
                     end else if (p < cur && p < anc) begin
                        // Ahead of both: left alone.
                     end else if (p > cur && p < anc) begin
                        p = p - 1'b1;
                     end else if (p > anc && p < cur) begin
                        p = p + 1'b1;
                     end else if (i == an) begin
                        if (!after && anc < cur) p = anc + 1'b1;
                        else if (after && anc > cur) p = anc - 1'b1;
                     end
                     entry_place[i] = p;
                  end
                  r.place = entry_place[mv];
               end
            end
         end
         expected_replies.push_back(r);
      endfunction

      // Compare one accepted result word with the oldest expectation.
      function void check_reply(logic [oprt_pkg::STATUS_W-1:0] status,
                                logic [oprt_pkg::PLACE_W-1:0] place);
         reply_word_type r;
         if (expected_replies.size() == 0) begin
            errors++;
            $display("%0t: result word with nothing expected, expected none, %s %0d %s %0d",
                     $time, "got status", status, "place", place);
            return;
         end
         r = expected_replies.pop_front();
         if (status !== r.status) begin
            errors++;
            $display("%0t: status mismatch, expected %0d, got %0d", $time, r.status, status);
         end
         if (place !== r.place) begin
            errors++;
            $display("%0t: new_place mismatch, expected %0d, got %0d", $time, r.place, place);
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   oprt_req_if #(.ID_BITS(ID_W)) req_chan ();
   oprt_rsp_if                   rsp_chan ();

   ordered_position_reorder_table_unit #(
      .DEPTH   (TABLE_DEPTH),
      .ID_BITS (ID_W)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   place_table_scoreboard book;
   logic [ID_W-1:0] pool_id [TABLE_DEPTH];
   int  burst_left;
   bit  sender_idle_on;
   bit  receiver_stalls_on;
   bit  start_long_hold;
   int  hold_left;
   int  pattern_age;
   logic [7:0] stall_pattern;
   int  idle_cycles;

   // Clock.
   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Known values on every input from time zero.
   initial begin
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.mode      = oprt_pkg::MODE_WRITE;
      req_chan.slot      = '0;
      req_chan.item_id   = '0;
      req_chan.anchor_id = '0;
      req_chan.place     = '0;
      rsp_chan.ready     = 1'b0;
      book               = new;
      burst_left         = 0;
      sender_idle_on     = 1'b1;
      receiver_stalls_on = 1'b1;
      start_long_hold    = 1'b0;
      hold_left          = 0;
      pattern_age        = 0;
      stall_pattern      = 8'hFF;
      idle_cycles        = 0;
   end

   // Receiver: a long hold-off on request, otherwise a rotating stall pattern.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_chan.ready <= 1'b0;
      end else if (start_long_hold) begin
         start_long_hold = 1'b0;
         hold_left = LONG_HOLD - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         if (pattern_age == 0) begin
            if (!receiver_stalls_on || $urandom_range(0, 3) == 0) stall_pattern = 8'hFF;
            else stall_pattern = 8'($urandom) | 8'h01;
            pattern_age = 48;
         end
         pattern_age = pattern_age - 1;
         rsp_chan.ready <= stall_pattern[0];
         stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
      end
   end

   // Result checking at the rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         book.check_reply(rsp_chan.status, rsp_chan.new_place);
   end

   // Count cycles in which no word moves on either channel.
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin : watchdog
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   // Offer one request word, wait for it to be taken, then maybe idle.
   task automatic send_word(input oprt_pkg::mode_type m,
                            input logic [oprt_pkg::SLOT_W-1:0] s,
                            input logic [ID_W-1:0] id, input logic [ID_W-1:0] anc,
                            input logic [oprt_pkg::PLACE_W-1:0] pl);
      int gap;
      @(negedge clock);
      req_chan.valid     <= 1'b1;
      req_chan.mode      <= m;
      req_chan.slot      <= s;
      req_chan.item_id   <= id;
      req_chan.anchor_id <= anc;
      req_chan.place     <= pl;
      do @(posedge clock); while (!req_chan.ready);
      book.note_request(m, s, id, anc, pl);
      if (sender_idle_on) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            gap = $urandom_range(1, 12);
            burst_left = $urandom_range(0, 20);
            @(negedge clock);
            req_chan.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   // Sender pause until every expected result word has come back. The last
   // word is withdrawn first so that it is not taken a second time.
   task automatic wait_drained();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (book.expected_replies.size() != 0) @(posedge clock);
   endtask

   // Fill all slots with fresh ids and a shuffled order.
   task automatic refill_table();
      int perm [TABLE_DEPTH];
      int j;
      int tmp;
      for (int i = 0; i < TABLE_DEPTH; i++) perm[i] = i;
      for (int i = TABLE_DEPTH - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = perm[i];
         perm[i] = perm[j];
         perm[j] = tmp;
      end
      for (int s = 0; s < TABLE_DEPTH; s++) begin
         pool_id[s] = ID_W'($urandom_range(1, 16'hFFFE));
         send_word(oprt_pkg::MODE_WRITE, oprt_pkg::SLOT_W'(s), pool_id[s],
                   ID_W'($urandom), oprt_pkg::PLACE_W'(perm[s]));
      end
   endtask

   // One random word: mostly moves on known ids, with some noise.
   task automatic random_word();
      int                 pick;
      int                 a_pick;
      logic [ID_W-1:0]    id;
      logic [ID_W-1:0]    anc;
      oprt_pkg::mode_type m;
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 9) < 9) id = pool_id[$urandom_range(0, TABLE_DEPTH - 1)];
      else id = ID_W'($urandom);
      a_pick = $urandom_range(0, 99);
      if (a_pick < 10) anc = HEAD_CODE;
      else if (a_pick < 20) anc = TAIL_CODE;
      else if (a_pick < 90) anc = pool_id[$urandom_range(0, TABLE_DEPTH - 1)];
      else anc = ID_W'($urandom);
      if (pick < 15) m = oprt_pkg::MODE_WRITE;
      else if (pick < 47) m = oprt_pkg::MODE_BEFORE;
      else if (pick < 80) m = oprt_pkg::MODE_AFTER;
      else m = oprt_pkg::MODE_QUERY;
      send_word(m, oprt_pkg::SLOT_W'($urandom), id, anc, oprt_pkg::PLACE_W'($urandom));
   endtask

   // Main sequence.
   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed words on an empty and then a small hand-built table.
      send_word(oprt_pkg::MODE_QUERY,  4'd0,  16'h1234, 16'h0000, 4'd0);
      send_word(oprt_pkg::MODE_BEFORE, 4'd0,  16'h0000, HEAD_CODE, 4'd0);
      send_word(oprt_pkg::MODE_WRITE,  4'd0,  16'h0000, 16'h0000, 4'd0);
      send_word(oprt_pkg::MODE_WRITE,  4'd15, 16'hFFFF, 16'hFFFF, 4'd15);
      send_word(oprt_pkg::MODE_WRITE,  4'd1,  16'h1111, 16'h0000, 4'd1);
      send_word(oprt_pkg::MODE_WRITE,  4'd2,  16'h2222, 16'h0000, 4'd2);
      send_word(oprt_pkg::MODE_WRITE,  4'd3,  16'h3333, 16'h0000, 4'd3);
      send_word(oprt_pkg::MODE_WRITE,  4'd4,  16'h1111, 16'h0000, 4'd9);
      send_word(oprt_pkg::MODE_QUERY,  4'd0,  16'h1111, 16'hFFFF, 4'd15);
      send_word(oprt_pkg::MODE_BEFORE, 4'd0,  16'h3333, HEAD_CODE, 4'd0);
      send_word(oprt_pkg::MODE_AFTER,  4'd0,  16'h0000, TAIL_CODE, 4'd0);
      send_word(oprt_pkg::MODE_BEFORE, 4'd0,  16'h2222, 16'h3333, 4'd0);
      send_word(oprt_pkg::MODE_AFTER,  4'd0,  16'h3333, 16'h2222, 4'd0);
      send_word(oprt_pkg::MODE_BEFORE, 4'd0,  16'h1111, 16'h1111, 4'd0);
      send_word(oprt_pkg::MODE_AFTER,  4'd0,  16'h2222, 16'h5555, 4'd0);
      send_word(oprt_pkg::MODE_BEFORE, 4'd0,  16'h4444, 16'h2222, 4'd0);
      send_word(oprt_pkg::MODE_AFTER,  4'd0,  16'hFFFF, HEAD_CODE, 4'd0);
      send_word(oprt_pkg::MODE_BEFORE, 4'd0,  16'h0000, TAIL_CODE, 4'd0);
      send_word(oprt_pkg::MODE_AFTER,  4'd0,  16'h1111, 16'h0000 | 16'h3333, 4'd0);
      send_word(oprt_pkg::MODE_BEFORE, 4'd0,  16'h3333, 16'hFFFF, 4'd0);
      send_word(oprt_pkg::MODE_QUERY,  4'd0,  16'h4444, 16'h0000, 4'd0);
      send_word(oprt_pkg::MODE_QUERY,  4'd0,  16'hFFFF, 16'h0000, 4'd0);
      send_word(oprt_pkg::MODE_QUERY,  4'd0,  16'h0000, 16'h0000, 4'd0);
      send_word(oprt_pkg::MODE_WRITE,  4'd4,  16'hA5A5, 16'h5A5A, 4'd15);
      send_word(oprt_pkg::MODE_QUERY,  4'd0,  16'h1111, 16'h0000, 4'd0);
      wait_drained();

      // Random phases: phase 1 holds the receiver off while the sender
      // keeps offering, phase 2 runs with no idling on either side.
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         sender_idle_on     = (ph != 1 && ph != 2);
         receiver_stalls_on = (ph != 2);
         if (ph == 1) start_long_hold = 1'b1;
         refill_table();
         for (int n = 0; n < PHASE_WORDS; n++) random_word();
         wait_drained();
      end

      @(negedge clock);
      req_chan.valid <= 1'b0;
      wait_drained();
      // Allow time for any stray result word to show up.
      repeat (8) @(posedge clock);

      $display("Run covered %0d writes, %0d moves (%0d to head, %0d to tail) and %0d queries.",
               book.n_write, book.n_move, book.n_head, book.n_tail, book.n_query);
      $display("Missing ids seen: %0d, missing anchors seen: %0d, mismatches: %0d.",
               book.n_no_id, book.n_no_anchor, book.errors);
      if (book.errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/oprt_pkg.sv
rtl/oprt_req_if.sv
rtl/oprt_rsp_if.sv
rtl/oprt_ctrl.sv
rtl/oprt_dp.sv
rtl/ordered_position_reorder_table_unit.sv
bench/ordered_position_reorder_table_unit_tb.sv
